// ----- design/vn3_pkg.sv -----
// vn3_pkg: widths, pipeline data types and constants for vector_normalize_3d
// no dependencies
package vn3_pkg;

  localparam int IN_WIDTH      = 32;
  localparam int OUT_FRAC_BITS = 30;
  localparam int OUT_WIDTH     = 32;

  // squared magnitude, sum of three squares
  localparam int SQ_WIDTH  = 2 * IN_WIDTH;
  localparam int SUM_WIDTH = 2 * IN_WIDTH + 2;
  // residual and doubled partial product of the digit recurrence
  localparam int ACC_WIDTH = 2 * IN_WIDTH + OUT_FRAC_BITS + 8;
  // unit magnitude, one bit per digit step
  localparam int Q_WIDTH   = OUT_FRAC_BITS + 1;
  localparam int NUM_STEPS = OUT_FRAC_BITS + 1;

  // front end stages + digit steps + output stage
  localparam int PIPE_DEPTH = 3 + NUM_STEPS + 1;

  localparam logic [Q_WIDTH-1:0] Q_ONE = Q_WIDTH'(1) << OUT_FRAC_BITS;

  typedef struct packed {
    logic [ACC_WIDTH-1:0] rem;  // residual, scaled for the next step
    logic [ACC_WIDTH-1:0] p2;   // twice the partial quotient times the sum
    logic [Q_WIDTH-1:0]   q;    // result bits found so far
  } lane_t;

  typedef struct packed {
    logic                 vld;
    logic                 zero;
    logic [2:0]           neg;
    logic [SUM_WIDTH-1:0] s;
    lane_t [2:0]          ln;
  } step_t;

endpackage

// ----- design/vn3_sumsq.sv -----
// vn3_sumsq: magnitudes, squares and sum of squares, three register stages
// depends on vn3_pkg
module vn3_sumsq
  import vn3_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic [IN_WIDTH-1:0]  x_i,
  input  logic [IN_WIDTH-1:0]  y_i,
  input  logic [IN_WIDTH-1:0]  z_i,
  output step_t                step_o
);

  logic [2:0][IN_WIDTH-1:0] raw;
  logic [2:0][IN_WIDTH-1:0] mag_d, mag_q;
  logic [2:0]               neg_d, neg_a_q, neg_b_q;
  logic [2:0][SQ_WIDTH-1:0] sq_d, sq_q;
  logic                     vld_a_q, vld_b_q;
  logic [SUM_WIDTH-1:0]     s_d;
  step_t                    step_d, step_q;

  assign raw = {z_i, y_i, x_i};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg_d[k] = raw[k][IN_WIDTH-1];
      mag_d[k] = neg_d[k] ? (IN_WIDTH'(0) - raw[k]) : raw[k];
      sq_d[k]  = SQ_WIDTH'(mag_q[k]) * SQ_WIDTH'(mag_q[k]);
    end
  end

  assign s_d = SUM_WIDTH'(sq_q[0]) + SUM_WIDTH'(sq_q[1]) + SUM_WIDTH'(sq_q[2]);

  always_comb begin
    step_d.vld  = vld_b_q;
    step_d.zero = (s_d == '0);
    step_d.neg  = neg_b_q;
    step_d.s    = s_d;
    for (int k = 0; k < 3; k++) begin
      step_d.ln[k].rem = ACC_WIDTH'(sq_q[k]);
      step_d.ln[k].p2  = '0;
      step_d.ln[k].q   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    neg_a_q <= neg_d;
    sq_q    <= sq_d;
    neg_b_q <= neg_a_q;
    step_q  <= step_d;
  end

  // valid bit of the last stage needs a reset of its own
  logic vld_c_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else begin
      vld_c_q <= vld_b_q;
    end
  end

  always_comb begin
    step_o     = step_q;
    step_o.vld = vld_c_q;
  end

endmodule

// ----- design/vn3_digit.sv -----
// vn3_digit: one registered step of the unit magnitude digit search, three lanes
// depends on vn3_pkg
module vn3_digit
  import vn3_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  step_t step_i,
  output step_t step_o
);

  step_t step_d, step_q;
  logic  vld_q;

  always_comb begin
    logic [ACC_WIDTH+1:0] diff;
    logic                 take;
    logic [ACC_WIDTH-1:0] rem;
    logic [ACC_WIDTH-1:0] p2;
    step_d = step_i;
    for (int k = 0; k < 3; k++) begin
      // trial bit set: residual - 2*p2 - s must stay non-negative
      diff = {2'b00, step_i.ln[k].rem} - {1'b0, step_i.ln[k].p2, 1'b0}
             - (ACC_WIDTH+2)'(step_i.s);
      take = ~diff[ACC_WIDTH+1];
      rem  = take ? diff[ACC_WIDTH-1:0] : step_i.ln[k].rem;
      p2   = step_i.ln[k].p2 + (take ? ACC_WIDTH'(step_i.s) : ACC_WIDTH'(0));
      step_d.ln[k].rem = {rem[ACC_WIDTH-3:0], 2'b00};
      step_d.ln[k].p2  = {p2[ACC_WIDTH-2:0], 1'b0};
      step_d.ln[k].q   = {step_i.ln[k].q[Q_WIDTH-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= step_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
  end

  always_comb begin
    step_o     = step_q;
    step_o.vld = vld_q;
  end

endmodule

// ----- design/vector_normalize_3d.sv -----
// vector_normalize_3d: top level, unit vector of a signed 3d vector in Q1.30
// depends on vn3_pkg, vn3_sumsq, vn3_digit
//
// usage:
//   input channel: x_in_i, y_in_i, z_in_i are taken in at a clock edge where
//   start_i is high and busy_o is low; busy_o is always low, so one vector
//   transfer per cycle is sustained
//   result channel: valid_o marks x_unit_o, y_unit_o, z_unit_o, was_zero_o
//   for exactly one cycle; the receiver cannot hold results off and none is
//   needed since every stage moves each cycle
//   depth: PIPE_DEPTH registers from the input transfer to the result
//   (3 front end stages, 31 digit steps, 1 output register)
//   throughput: 1 vector per cycle, set by one digit step per pipeline stage
//   outputs truncate toward zero, saturate at +/-1.0, a zero vector gives
//   (1, 0, 0) with was_zero_o set
//   reset: valid bits clear at once, anything in flight is dropped
module vector_normalize_3d
  import vn3_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [IN_WIDTH-1:0]  x_in_i,
  input  logic signed [IN_WIDTH-1:0]  y_in_i,
  input  logic signed [IN_WIDTH-1:0]  z_in_i,
  output logic                        valid_o,
  output logic signed [OUT_WIDTH-1:0] x_unit_o,
  output logic signed [OUT_WIDTH-1:0] y_unit_o,
  output logic signed [OUT_WIDTH-1:0] z_unit_o,
  output logic                        was_zero_o
);

  localparam int StrobeDly = PIPE_DEPTH;
  localparam logic signed [OUT_WIDTH-1:0] OutOne = OUT_WIDTH'(Q_ONE);

  // never stalls
  assign busy_o = 1'b0;

  step_t st [0:NUM_STEPS];

  vn3_sumsq u_sumsq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i & ~busy_o),
    .x_i    (x_in_i),
    .y_i    (y_in_i),
    .z_i    (z_in_i),
    .step_o (st[0])
  );

  // one result bit per stage, most significant first
  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_digit
    vn3_digit u_digit (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (st[g]),
      .step_o (st[g+1])
    );
  end

  // output stage: clamp, apply sign, zero vector default
  logic [2:0][OUT_WIDTH-1:0] unit_d, unit_q;
  logic                      zero_q;
  logic                      valid_q;

  always_comb begin
    logic [Q_WIDTH-1:0]   q;
    logic [OUT_WIDTH-1:0] mag;
    for (int k = 0; k < 3; k++) begin
      q   = (st[NUM_STEPS].ln[k].q > Q_ONE) ? Q_ONE : st[NUM_STEPS].ln[k].q;
      mag = OUT_WIDTH'(q);
      unit_d[k] = st[NUM_STEPS].neg[k] ? (OUT_WIDTH'(0) - mag) : mag;
    end
    if (st[NUM_STEPS].zero) begin
      unit_d[0] = OUT_WIDTH'(Q_ONE);
      unit_d[1] = '0;
      unit_d[2] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= st[NUM_STEPS].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
    zero_q <= st[NUM_STEPS].zero;
  end

  assign valid_o    = valid_q;
  assign x_unit_o   = unit_q[0];
  assign y_unit_o   = unit_q[1];
  assign z_unit_o   = unit_q[2];
  assign was_zero_o = zero_q;

`ifndef NO_ASSERTIONS
  // every transfer yields its result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##StrobeDly valid_o)
    else $error("result strobe missing after input transfer");

  // zero vector result is exactly (1, 0, 0)
  a_zero_default: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && was_zero_o) |-> (x_unit_o == OutOne && y_unit_o == '0 && z_unit_o == '0))
    else $error("zero vector default wrong");

  // saturation bound holds on every lane
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (x_unit_o <= OutOne && x_unit_o >= -OutOne &&
                 y_unit_o <= OutOne && y_unit_o >= -OutOne &&
                 z_unit_o <= OutOne && z_unit_o >= -OutOne))
    else $error("unit component beyond one");
`endif

endmodule

// ----- dv/tb_vector_normalize_3d.sv -----
// tb_vector_normalize_3d: self-checking testbench for the 3d unit-vector block
// depends on vn3_pkg and vector_normalize_3d; predicts each unit vector and
// compares every result transfer in order
`timescale 1ns / 100ps

module tb_vector_normalize_3d;
  import vn3_pkg::*;

  localparam int LATENCY     = PIPE_DEPTH;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic signed [OUT_WIDTH-1:0] xu;
    logic signed [OUT_WIDTH-1:0] yu;
    logic signed [OUT_WIDTH-1:0] zu;
    logic                        zero;
  } unit_vec_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic signed [IN_WIDTH-1:0]  x_in_i = '0;
  logic signed [IN_WIDTH-1:0]  y_in_i = '0;
  logic signed [IN_WIDTH-1:0]  z_in_i = '0;
  logic                        valid_o;
  logic signed [OUT_WIDTH-1:0] x_unit_o;
  logic signed [OUT_WIDTH-1:0] y_unit_o;
  logic signed [OUT_WIDTH-1:0] z_unit_o;
  logic                        was_zero_o;

  unit_vec_t pending_units[$];
  int        error_count = 0;
  int        cycle_count = 0;

  vector_normalize_3d dut (.*);

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_vector_normalize_3d failed");
      $finish;
    end
  end

  // magnitude of a component, most negative value included
  function automatic logic [IN_WIDTH-1:0] comp_mag(logic signed [IN_WIDTH-1:0] c);
    return c[IN_WIDTH-1] ? IN_WIDTH'(-c) : c;
  endfunction

  // largest q with q*q*s <= m*m*2^(2F), found one bit at a time, capped at one
  function automatic logic signed [OUT_WIDTH-1:0] unit_comp(
      logic signed [IN_WIDTH-1:0] c, logic [SUM_WIDTH-1:0] s);
    logic [IN_WIDTH-1:0] m;
    logic [191:0]        target;
    logic [191:0]        trial;
    logic [Q_WIDTH:0]    q;
    logic [Q_WIDTH:0]    t;
    m = comp_mag(c);
    target = (192'(m) * 192'(m)) << (2 * OUT_FRAC_BITS);
    q = '0;
    for (int b = OUT_FRAC_BITS; b >= 0; b--) begin
      t = q | ((Q_WIDTH + 1)'(1) << b);
      trial = 192'(t) * 192'(t) * 192'(s);
      if (trial <= target) q = t;
    end
    if (q > (Q_WIDTH + 1)'(Q_ONE)) q = (Q_WIDTH + 1)'(Q_ONE);
    return c[IN_WIDTH-1] ? -OUT_WIDTH'(q) : OUT_WIDTH'(q);
  endfunction

  function automatic unit_vec_t normalize(logic signed [IN_WIDTH-1:0] x,
      logic signed [IN_WIDTH-1:0] y, logic signed [IN_WIDTH-1:0] z);
    unit_vec_t       u;
    logic [SUM_WIDTH-1:0] s;
    s = SUM_WIDTH'(comp_mag(x)) * comp_mag(x) + SUM_WIDTH'(comp_mag(y)) * comp_mag(y)
      + SUM_WIDTH'(comp_mag(z)) * comp_mag(z);
    if (s == '0) begin
      u.xu = OUT_WIDTH'(Q_ONE);
      u.yu = '0;
      u.zu = '0;
      u.zero = 1'b1;
    end else begin
      u.xu = unit_comp(x, s);
      u.yu = unit_comp(y, s);
      u.zu = unit_comp(z, s);
      u.zero = 1'b0;
    end
    return u;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // one vector transfer, random hold-off before it
  task automatic send_vector(logic signed [IN_WIDTH-1:0] x,
      logic signed [IN_WIDTH-1:0] y, logic signed [IN_WIDTH-1:0] z);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    x_in_i  <= x;
    y_in_i  <= y;
    z_in_i  <= z;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_units.push_back(normalize(x, y, z));
  endtask

  // result checker: every valid cycle is one result transfer
  always @(posedge clk_i) begin
    unit_vec_t exp_u;
    if (rst_ni && valid_o) begin
      if (pending_units.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        exp_u = pending_units.pop_front();
        if (x_unit_o !== exp_u.xu) report_mismatch("x_unit", x_unit_o, exp_u.xu);
        if (y_unit_o !== exp_u.yu) report_mismatch("y_unit", y_unit_o, exp_u.yu);
        if (z_unit_o !== exp_u.zu) report_mismatch("z_unit", z_unit_o, exp_u.zu);
        if (was_zero_o !== exp_u.zero) report_mismatch("was_zero", was_zero_o, exp_u.zero);
      end
    end
  end

  localparam logic signed [IN_WIDTH-1:0] MAX_C = {1'b0, {(IN_WIDTH-1){1'b1}}};
  localparam logic signed [IN_WIDTH-1:0] MIN_C = {1'b1, {(IN_WIDTH-1){1'b0}}};

  // zero vector, lone axes, extremes and most negative inputs
  task automatic test_special_vectors();
    send_vector(0, 0, 0);
    send_vector(1, 0, 0);
    send_vector(0, -1, 0);
    send_vector(0, 0, MAX_C);
    send_vector(MIN_C, 0, 0);
    send_vector(0, MIN_C, 0);
    send_vector(0, 0, MIN_C);
    send_vector(MIN_C, MIN_C, MIN_C);
    send_vector(MAX_C, MAX_C, MAX_C);
    send_vector(MAX_C, MIN_C, MAX_C);
    send_vector(-1, -1, -1);
    send_vector(1, 1, 1);
    send_vector(3, 4, 0);
    send_vector(-3, 4, 0);
    send_vector(1, 2, 2);
    send_vector(MAX_C, 1, 0);
    send_vector(1, 0, MIN_C);
    send_vector(-32'sd1, MAX_C, 0);
  endtask

  function automatic logic signed [IN_WIDTH-1:0] rand_comp();
    case ($urandom_range(0, 4))
      0:       return IN_WIDTH'($urandom);
      1:       return IN_WIDTH'($signed($urandom_range(0, 512)) - 256);
      2:       return IN_WIDTH'($signed($urandom) >>> $urandom_range(0, 31));
      3:       return $urandom_range(0, 1) ? MIN_C : MAX_C;
      default: return '0;
    endcase
  endfunction

  // random vectors, mixed scales, 2d and zero vectors included
  task automatic test_random_vectors(int count);
    logic signed [IN_WIDTH-1:0] z;
    for (int i = 0; i < count; i++) begin
      z = ($urandom_range(0, 4) == 0) ? '0 : rand_comp();
      send_vector(rand_comp(), rand_comp(), z);
    end
  endtask

  // back-to-back transfers with no hold-off
  task automatic test_streaming(int count);
    for (int i = 0; i < count; i++) begin
      start_i <= 1'b1;
      x_in_i  <= IN_WIDTH'($urandom);
      y_in_i  <= IN_WIDTH'($urandom);
      z_in_i  <= IN_WIDTH'($urandom);
      @(posedge clk_i);
      while (busy_o) @(posedge clk_i);
      pending_units.push_back(normalize(x_in_i, y_in_i, z_in_i));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_vectors();
    test_random_vectors(400);
    test_streaming(80);
    start_i <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_vector_normalize_3d passed");
    end else begin
      $display("tb_vector_normalize_3d failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/vn3_pkg.sv
design/vn3_sumsq.sv
design/vn3_digit.sv
design/vector_normalize_3d.sv
dv/tb_vector_normalize_3d.sv
